[src/drs_pkg.sv]
// Package for the recency stack with duplicate removal.
// Field widths, request and status codes, FSM state and per-cell control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package drs_pkg;
	localparam int KEY_W     = 32;
	localparam int PAY_W     = 32;
	localparam int FILL_W    = 9;
	localparam int DEPTH_DEF = 256;

	localparam logic REQ_PUSH   = 1'b0;
	localparam logic REQ_POP    = 1'b1;
	localparam logic STAT_OK    = 1'b0;
	localparam logic STAT_EMPTY = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_APPLY
	} state_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic hit_any;
	} cell_ctl_t;
endpackage
`default_nettype wire

[src/drs_req_if.sv]
// Request and response channel interfaces (valid/ready plus payload).
// Depends on drs_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface drs_req_if;
	import drs_pkg::*;
	logic             valid;
	logic             ready;
	logic             req_type;
	logic [KEY_W-1:0] entry_key;
	logic [PAY_W-1:0] entry_payload;
	modport source (output valid, req_type, entry_key, entry_payload, input ready);
	modport sink (input valid, req_type, entry_key, entry_payload, output ready);
endinterface

interface drs_rsp_if;
	import drs_pkg::*;
	logic              valid;
	logic              ready;
	logic [KEY_W-1:0]  popped_key;
	logic [PAY_W-1:0]  popped_payload;
	logic              status;
	logic              now_empty;
	logic [FILL_W-1:0] fill_count;
	modport source (output valid, popped_key, popped_payload, status, now_empty, fill_count,
		input ready);
	modport sink (input valid, popped_key, popped_payload, status, now_empty, fill_count,
		output ready);
endinterface
`default_nettype wire

[src/drs_cell.sv]
// One stack cell: holds a key/payload pair, compares its key, shifts from a neighbor.
// Depends on drs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module drs_cell #(
	parameter int DEPTH = drs_pkg::DEPTH_DEF,
	parameter int IDX_W = 8,
	parameter int CNT_W = 9,
	parameter int IDX   = 0
) (
	input  wire logic                     clk,
	input  wire drs_pkg::cell_ctl_t       ctl,
	input  wire logic [IDX_W-1:0]         hit_idx,
	input  wire logic [CNT_W-1:0]         count,
	input  wire logic [drs_pkg::KEY_W-1:0] cmp_key,
	input  wire logic [drs_pkg::KEY_W-1:0] up_key,
	input  wire logic [drs_pkg::PAY_W-1:0] up_payload,
	input  wire logic [drs_pkg::KEY_W-1:0] dn_key,
	input  wire logic [drs_pkg::PAY_W-1:0] dn_payload,
	output logic      [drs_pkg::KEY_W-1:0] key,
	output logic      [drs_pkg::PAY_W-1:0] payload,
	output logic                          hit
);
	import drs_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] payload_q;
	logic             live;
	logic             take_up;

	assign live    = CNT_W'(IDX) < count;
	assign hit     = live && (key_q == cmp_key);
	assign take_up = ctl.push && (!ctl.hit_any || (IDX_W'(IDX) <= hit_idx));
	assign key     = key_q;
	assign payload = payload_q;

	// top of stack is cell 0; push shifts down to the removed duplicate, pop shifts up
	always_ff @(posedge clk) begin
		if (take_up) begin
			key_q     <= up_key;
			payload_q <= up_payload;
		end else if (ctl.pop) begin
			key_q     <= dn_key;
			payload_q <= dn_payload;
		end
	end
endmodule
`default_nettype wire

[src/dedup_recency_stack.sv]
// Recency stack of DEPTH key/payload entries with duplicate removal on push.
// Request channel req (sink), response channel rsp (source); each request gives one response.
// Push (req_type 0) removes the entry with the same key, drops the oldest entry when the
// stack is full, then places the new entry on top; fill_count reports entries held.
// Pop (req_type 1) returns the top entry; on an empty stack it returns zeros with status 1.
// Structure: a row of DEPTH cells, cell 0 on top. All cells compare their key against the
// incoming key in the cycle the request transfers; the single hit is encoded to an index.
// In the shift cycle, which waits while the output register is full, every cell from the top
// down to and including the hit (or every cell, with no hit) takes its upper neighbor, or on
// pop every cell takes its lower neighbor. The response is registered when the shift commits.
// A new request is not taken until the shift of the last one has committed.
// The response sits in an output register; a new request is taken while it waits, but the
// shift cycle holds until that register is free, so a stalled receiver stalls the request
// side after one more request.
// Reset clears the entry count and the channel state; the stack is empty after reset.
`timescale 1ns / 1ps
`default_nettype none
module dedup_recency_stack #(
	parameter int DEPTH = drs_pkg::DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	drs_req_if.sink   req,
	drs_rsp_if.source rsp
);
	import drs_pkg::*;

	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WIDE_W = (CNT_W > FILL_W) ? CNT_W : FILL_W;

	state_t state_q, state_d;

	logic             req_type_s1;
	logic [KEY_W-1:0] key_s1;
	logic [PAY_W-1:0] pay_s1;
	logic             hit_any_s1;
	logic [IDX_W-1:0] hit_idx_s1;

	logic [DEPTH-1:0] hit;
	logic [KEY_W-1:0] cell_key [DEPTH];
	logic [PAY_W-1:0] cell_pay [DEPTH];
	logic             hit_any_d;
	logic [IDX_W-1:0] hit_idx_d;

	logic [CNT_W-1:0]  count_q, count_d;
	logic [WIDE_W-1:0] count_wide;
	cell_ctl_t         ctl;
	logic              out_free;
	logic              commit;
	logic              accept;
	logic              is_pop;
	logic              pop_empty;

	logic              rsp_valid_q;
	logic [KEY_W-1:0]  rsp_key_q;
	logic [PAY_W-1:0]  rsp_pay_q;
	logic              rsp_status_q;
	logic              rsp_empty_q;
	logic [FILL_W-1:0] rsp_fill_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_W-1:0] up_key, dn_key;
		logic [PAY_W-1:0] up_pay, dn_pay;
		if (i == 0) begin : g_top
			assign up_key = key_s1;
			assign up_pay = pay_s1;
		end else begin : g_mid
			assign up_key = cell_key[i-1];
			assign up_pay = cell_pay[i-1];
		end
		if (i == DEPTH - 1) begin : g_bot
			assign dn_key = '0;
			assign dn_pay = '0;
		end else begin : g_up
			assign dn_key = cell_key[i+1];
			assign dn_pay = cell_pay[i+1];
		end
		drs_cell #(
			.DEPTH(DEPTH),
			.IDX_W(IDX_W),
			.CNT_W(CNT_W),
			.IDX  (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.hit_idx   (hit_idx_s1),
			.count     (count_q),
			.cmp_key   (req.entry_key),
			.up_key    (up_key),
			.up_payload(up_pay),
			.dn_key    (dn_key),
			.dn_payload(dn_pay),
			.key       (cell_key[i]),
			.payload   (cell_pay[i]),
			.hit       (hit[i])
		);
	end

	// held keys are unique, so at most one hit: OR-encode its index
	always_comb begin
		hit_idx_d = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (hit[i]) begin
				hit_idx_d = hit_idx_d | IDX_W'(i);
			end
		end
		hit_any_d = |hit;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign is_pop    = req_type_s1 == REQ_POP;
	assign pop_empty = is_pop && (count_q == '0);

	always_comb begin
		req.ready = 1'b0;
		commit    = 1'b0;
		case (state_q)
			ST_IDLE:  req.ready = 1'b1;
			ST_APPLY: commit    = out_free;
			default: begin
				req.ready = 1'b0;
				commit    = 1'b0;
			end
		endcase
	end

	assign accept      = req.valid && req.ready;
	assign ctl.push    = commit && !is_pop;
	assign ctl.pop     = commit && is_pop && !pop_empty;
	assign ctl.hit_any = hit_any_s1;

	always_comb begin
		if (!is_pop) begin
			if (hit_any_s1 || (count_q == CNT_W'(DEPTH))) begin
				count_d = count_q;
			end else begin
				count_d = count_q + CNT_W'(1);
			end
		end else if (pop_empty) begin
			count_d = '0;
		end else begin
			count_d = count_q - CNT_W'(1);
		end
	end
	assign count_wide = WIDE_W'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1 <= req.req_type;
			key_s1      <= req.entry_key;
			pay_s1      <= req.entry_payload;
			hit_any_s1  <= hit_any_d;
			hit_idx_s1  <= hit_idx_d;
		end
		if (commit) begin
			rsp_key_q    <= (is_pop && !pop_empty) ? cell_key[0] : '0;
			rsp_pay_q    <= (is_pop && !pop_empty) ? cell_pay[0] : '0;
			rsp_status_q <= pop_empty ? STAT_EMPTY : STAT_OK;
			rsp_empty_q  <= count_d == '0;
			rsp_fill_q   <= count_wide[FILL_W-1:0];
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.popped_key     = rsp_key_q;
	assign rsp.popped_payload = rsp_pay_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.now_empty      = rsp_empty_q;
	assign rsp.fill_count     = rsp_fill_q;

`ifndef ASSERT_OFF
	a_unique_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit))
		else $error("more than one held entry matches the key");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");
	a_accept_apply: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_APPLY))
		else $error("accepted request did not reach the shift cycle");
	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_status_q == STAT_EMPTY)) |-> (rsp_empty_q && (rsp_fill_q == '0)))
		else $error("empty-pop response reports held entries");
`endif
endmodule
`default_nettype wire
